/* src/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tpa_pkg.sv */
package tpa_pkg;

    localparam int FRAME_PIXELS   = 65536;
    localparam int ADDR_W         = 16;
    localparam int MAX_WINDOW_DEF = 16;
    localparam int CHANS          = 4;
    localparam int PIX_W          = 8;
    localparam int ACC_W          = 16;
    localparam int ACC_WORD_W     = CHANS * ACC_W;
    localparam int PIX_WORD_W     = CHANS * PIX_W;
    localparam int LUMA_W         = 36;
    localparam int RECIP_SHIFT    = 22;
    localparam int RECIP_W        = RECIP_SHIFT + 1;
    localparam int PROD_W         = ACC_W + 1 + RECIP_W;

    localparam logic [PIX_W-1:0] MID_LEVEL = 8'h80;
    localparam logic [PIX_W-1:0] TOP_LEVEL = 8'hff;

    localparam logic signed [ACC_W-1:0] ACC_HI = 16'sh7fff;
    localparam logic signed [ACC_W-1:0] ACC_LO = 16'sh8000;

    localparam logic signed [LUMA_W-1:0] WEIGHT_R = 36'sd19595;
    localparam logic signed [LUMA_W-1:0] WEIGHT_G = 36'sd38470;
    localparam logic signed [LUMA_W-1:0] WEIGHT_B = 36'sd7471;

    // Bit positions within the color format register.
    localparam int FMT_FOUR_BIT = 0;
    localparam int FMT_YUV_BIT  = 1;

    typedef enum logic [2:0] {
        MODE_AVERAGE    = 3'd0,
        MODE_ACCUMULATE = 3'd1,
        MODE_GREATER    = 3'd2,
        MODE_LESS       = 3'd3,
        MODE_REPLACE    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_WINDOW  = 3'd1,
        REG_NO_SUB  = 3'd2,
        REG_KEY_THR = 3'd3,
        REG_FORMAT  = 3'd4
    } t_cfg_reg;

    // Weighted RGB luma with 16 fraction bits.
    function automatic logic signed [LUMA_W-1:0] luma(
        input logic signed [ACC_W:0] r,
        input logic signed [ACC_W:0] g,
        input logic signed [ACC_W:0] b
    );
        return WEIGHT_R * LUMA_W'(r) + WEIGHT_G * LUMA_W'(g) + WEIGHT_B * LUMA_W'(b);
    endfunction

endpackage

/* src/tpa_ram.sv */
module tpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read returns the old word when it meets a write to the same address.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/temporal_pixel_averager.sv */
// An accepted request passes the stage registers r1 to r4 before its result reaches the output register r5.
// Throughput: one pixel per cycle; the whole pipeline holds while the output waits.
// Accumulator and frame ring live in single-port-write RAMs with registered reads;
// read-after-write hazards on one pixel address are covered by forwarding.
// Reset clears valid bits, ring slot and fill count, and marks the next frame fresh;
// the RAMs are not cleared.
`include "assert_macros.svh"

module temporal_pixel_averager #(
    parameter int MAX_WINDOW = tpa_pkg::MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pixel_addr, chan0, chan1, chan2, chan3
    input  logic        s_axis_tlast,   // frame_end
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_chan0, out_chan1, out_chan2, out_chan3
    output logic        m_axis_tlast,   // out_frame_end
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int AW    = tpa_pkg::ADDR_W;
    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int HAW   = SW + AW;
    localparam int HDEP  = MAX_WINDOW * tpa_pkg::FRAME_PIXELS;
    localparam int AWW   = tpa_pkg::ACC_WORD_W;
    localparam int PWW   = tpa_pkg::PIX_WORD_W;
    localparam int ACCW  = tpa_pkg::ACC_W;
    localparam int PW    = tpa_pkg::PIX_W;
    localparam int LW    = tpa_pkg::LUMA_W;
    localparam int CH    = tpa_pkg::CHANS;

    // ---------------- configuration ----------------
    logic [2:0] r_mode;
    logic [4:0] r_window;
    logic       r_no_sub;
    logic [7:0] r_key_thr;
    logic [1:0] r_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 3'(tpa_pkg::MODE_AVERAGE);
            r_window  <= 5'd1;
            r_no_sub  <= 1'b0;
            r_key_thr <= 8'd1;
            r_format  <= 2'd0;
        end else if (i_cfg_wr_en) begin
            unique case (tpa_pkg::t_cfg_reg'(i_cfg_index))
                tpa_pkg::REG_MODE:    r_mode    <= i_cfg_wdata[2:0];
                tpa_pkg::REG_WINDOW:  r_window  <= i_cfg_wdata[4:0];
                tpa_pkg::REG_NO_SUB:  r_no_sub  <= i_cfg_wdata[0];
                tpa_pkg::REG_KEY_THR: r_key_thr <= i_cfg_wdata;
                tpa_pkg::REG_FORMAT:  r_format  <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    tpa_pkg::t_mode  w_mode;
    logic            w_yuv;
    logic            w_four;
    logic [NW-1:0]   w_n;
    logic [PW-1:0]   w_off;
    logic            w_avg_acc;

    always_comb begin
        w_mode = (r_mode > 3'(tpa_pkg::MODE_REPLACE)) ? tpa_pkg::MODE_ACCUMULATE
                                                      : tpa_pkg::t_mode'(r_mode);
        w_yuv  = r_format[tpa_pkg::FMT_YUV_BIT];
        w_four = r_format[tpa_pkg::FMT_FOUR_BIT];
        if (r_window == 5'd0) begin
            w_n = NW'(1);
        end else if (32'(r_window) > MAX_WINDOW) begin
            w_n = NW'(MAX_WINDOW);
        end else begin
            w_n = NW'(r_window);
        end
        w_off     = w_yuv ? tpa_pkg::MID_LEVEL : '0;
        w_avg_acc = (w_mode == tpa_pkg::MODE_AVERAGE) || (w_mode == tpa_pkg::MODE_ACCUMULATE);
    end

    // Reciprocals for the average divider: ceil(2^shift / n).
    logic [tpa_pkg::RECIP_W-1:0] w_recip [MAX_WINDOW+1];
    assign w_recip[0] = '0;
    for (genvar g = 1; g <= MAX_WINDOW; g++) begin : g_recip
        localparam logic [tpa_pkg::RECIP_W-1:0] RV =
            tpa_pkg::RECIP_W'(((1 << tpa_pkg::RECIP_SHIFT) + g - 1) / g);
        assign w_recip[g] = RV;
    end

    // ---------------- handshake ----------------
    logic r5_valid;
    logic adv;
    logic acc_in;

    assign adv           = !r5_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc_in        = s_axis_tvalid && adv;

    // ---------------- accept stage: frame bookkeeping ----------------
    logic [SW-1:0] r_ring;
    logic [NW-1:0] r_filled;
    logic          r_fresh;

    logic [AW-1:0] in_addr;
    logic          fresh_now;
    logic [NW-1:0] filled_now;
    logic          sub_now;
    logic [SW-1:0] slot_now;
    logic [SW-1:0] n_ring;
    logic [NW-1:0] n_filled;

    always_comb begin
        logic [SW+NW-1:0] rem;
        logic [NW:0]      inc;
        in_addr    = s_axis_tdata[AW-1:0];
        fresh_now  = s_axis_tuser || r_fresh;
        filled_now = fresh_now ? '0 : r_filled;
        sub_now    = !r_no_sub && w_avg_acc && (filled_now >= w_n);
        // Slot modulo window, one restoring step per slot bit.
        rem = (SW+NW)'(r_ring);
        for (int i = SW - 1; i >= 0; i--) begin
            if (rem >= ((SW+NW)'(w_n) << i)) begin
                rem = rem - ((SW+NW)'(w_n) << i);
            end
        end
        slot_now = SW'(rem);
        inc      = (NW+1)'(slot_now) + (NW+1)'(1);
        n_ring   = (inc >= (NW+1)'(w_n)) ? '0 : SW'(inc);
        if (fresh_now) begin
            n_filled = NW'(1);
        end else if (filled_now >= w_n) begin
            n_filled = w_n;
        end else begin
            n_filled = filled_now + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring   <= '0;
            r_filled <= '0;
            r_fresh  <= 1'b1;
        end else if (acc_in) begin
            r_fresh <= s_axis_tlast ? 1'b0 : fresh_now;
            if (s_axis_tlast) begin
                r_ring   <= n_ring;
                r_filled <= n_filled;
            end
        end
    end

    // ---------------- memories ----------------
    logic [AWW-1:0] acc_rd_data;
    logic [PWW-1:0] hist_rd_data;

    logic           r3_valid;
    logic [AW-1:0]  r3_addr;
    logic [HAW-1:0] r3_hidx;
    logic [PWW-1:0] r3_hist;
    logic [AWW-1:0] r3_acc;
    logic           r3_last;

    tpa_ram #(
        .WIDTH (AWW),
        .DEPTH (tpa_pkg::FRAME_PIXELS)
    ) u_acc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (adv && r3_valid),
        .i_wr_addr (r3_addr),
        .i_wr_data (r3_acc),
        .i_rd_en   (adv),
        .i_rd_addr (in_addr),
        .o_rd_data (acc_rd_data)
    );

    tpa_ram #(
        .WIDTH (PWW),
        .DEPTH (HDEP)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (adv && r3_valid),
        .i_wr_addr (r3_hidx),
        .i_wr_data (r3_hist),
        .i_rd_en   (adv),
        .i_rd_addr ({slot_now, in_addr}),
        .o_rd_data (hist_rd_data)
    );

    // ---------------- stage 1 ----------------
    logic           r1_valid;
    logic [AW-1:0]  r1_addr;
    logic [SW-1:0]  r1_slot;
    logic [PWW-1:0] r1_px;
    logic           r1_last;
    logic           r1_fresh;
    logic           r1_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= acc_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_addr  <= in_addr;
            r1_slot  <= slot_now;
            r1_px    <= s_axis_tdata[AW +: PWW];
            r1_last  <= s_axis_tlast;
            r1_fresh <= fresh_now;
            r1_sub   <= sub_now;
        end
    end

    logic signed [LW-1:0] w1_luma;
    assign w1_luma = tpa_pkg::luma($signed({9'd0, r1_px[0 +: PW]}),
                                   $signed({9'd0, r1_px[PW +: PW]}),
                                   $signed({9'd0, r1_px[2*PW +: PW]}));

    // ---------------- stage 2: read-modify ----------------
    logic                 r2_valid;
    logic [AW-1:0]        r2_addr;
    logic [HAW-1:0]       r2_hidx;
    logic [PWW-1:0]       r2_px;
    logic                 r2_last;
    logic                 r2_fresh;
    logic                 r2_sub;
    logic [AWW-1:0]       r2_acc_rd;
    logic [PWW-1:0]       r2_hist_rd;
    logic signed [LW-1:0] r2_luma_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_addr    <= r1_addr;
            r2_hidx    <= {r1_slot, r1_addr};
            r2_px      <= r1_px;
            r2_last    <= r1_last;
            r2_fresh   <= r1_fresh;
            r2_sub     <= r1_sub;
            r2_acc_rd  <= acc_rd_data;
            r2_hist_rd <= hist_rd_data;
            r2_luma_px <= w1_luma;
        end
    end

    logic           r4_valid;
    logic [AW-1:0]  r4_addr;
    logic [HAW-1:0] r4_hidx;
    logic [PWW-1:0] r4_hist;
    logic [AWW-1:0] r4_acc;
    logic [AW-1:0]  r5_addr;
    logic [HAW-1:0] r5_hidx;
    logic [PWW-1:0] r5_hist;
    logic [AWW-1:0] r5_acc;

    logic [AWW-1:0] w2_prev;
    logic [PWW-1:0] w2_hprev;
    logic [AWW-1:0] w2_fin;

    always_comb begin
        logic signed [ACCW-1:0] a0 [CH];
        logic signed [ACCW+1:0] s;
        logic signed [LW-1:0]   pk;
        logic signed [LW-1:0]   ak;
        logic [PW-1:0]          offk;
        logic [PW-1:0]          pxk;
        logic [PW-1:0]          hk;
        logic                   take;
        logic signed [ACCW-1:0] fk;

        // Forward results not yet visible in the RAMs, newest first.
        priority if (r3_valid && r3_addr == r2_addr) begin
            w2_prev = r3_acc;
        end else if (r4_valid && r4_addr == r2_addr) begin
            w2_prev = r4_acc;
        end else if (r5_valid && r5_addr == r2_addr) begin
            w2_prev = r5_acc;
        end else begin
            w2_prev = r2_acc_rd;
        end
        priority if (r3_valid && r3_hidx == r2_hidx) begin
            w2_hprev = r3_hist;
        end else if (r4_valid && r4_hidx == r2_hidx) begin
            w2_hprev = r4_hist;
        end else if (r5_valid && r5_hidx == r2_hidx) begin
            w2_hprev = r5_hist;
        end else begin
            w2_hprev = r2_hist_rd;
        end

        for (int k = 0; k < CH; k++) begin
            offk = (k == 1 || k == 2) ? w_off : '0;
            if (!r2_fresh) begin
                a0[k] = $signed(w2_prev[k*ACCW +: ACCW]);
            end else if (w_mode == tpa_pkg::MODE_LESS) begin
                a0[k] = (k == 1 || k == 2) && w_yuv ? $signed({8'd0, tpa_pkg::MID_LEVEL})
                                                    : $signed({8'd0, tpa_pkg::TOP_LEVEL});
            end else begin
                a0[k] = $signed({8'd0, offk});
            end
        end

        // Key compare for greater, less and replace.
        if (w_four) begin
            pk = LW'($signed({1'b0, r2_px[3*PW +: PW]}));
            ak = LW'(a0[3]);
        end else if (w_yuv) begin
            pk = LW'($signed({1'b0, r2_px[0 +: PW]}));
            ak = LW'(a0[0]);
        end else begin
            pk = r2_luma_px;
            ak = tpa_pkg::luma(17'(a0[0]), 17'(a0[1]), 17'(a0[2]));
        end
        unique case (w_mode)
            tpa_pkg::MODE_GREATER: take = pk > ak;
            tpa_pkg::MODE_LESS:    take = pk < ak;
            tpa_pkg::MODE_REPLACE: begin
                if (w_four) begin
                    take = r2_px[3*PW +: PW] > r_key_thr;
                end else if (w_yuv) begin
                    take = r2_px[0 +: PW] >= r_key_thr;
                end else begin
                    take = r2_luma_px >= LW'($signed({1'b0, r_key_thr, 16'd0}));
                end
            end
            default: take = 1'b0;
        endcase

        for (int k = 0; k < CH; k++) begin
            offk = (k == 1 || k == 2) ? w_off : '0;
            pxk  = r2_px[k*PW +: PW];
            hk   = w2_hprev[k*PW +: PW];
            s = 18'(a0[k]) + 18'($signed({10'd0, pxk})) - 18'($signed({10'd0, offk}));
            if (r2_sub) begin
                s = s - (18'($signed({10'd0, hk})) - 18'($signed({10'd0, offk})));
            end
            fk = a0[k];
            if (k < 3 || w_four) begin
                if (w_avg_acc) begin
                    if (s > 18'(tpa_pkg::ACC_HI)) begin
                        fk = tpa_pkg::ACC_HI;
                    end else if (s < 18'(tpa_pkg::ACC_LO)) begin
                        fk = tpa_pkg::ACC_LO;
                    end else begin
                        fk = 16'(s);
                    end
                end
                if (take) begin
                    fk = $signed({8'd0, pxk});
                end
            end
            w2_fin[k*ACCW +: ACCW] = fk;
        end
    end

    // ---------------- stage 3: write back, divide multiply ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_addr <= r2_addr;
            r3_hidx <= r2_hidx;
            r3_hist <= r2_px;
            r3_acc  <= w2_fin;
            r3_last <= r2_last;
        end
    end

    logic [tpa_pkg::PROD_W-1:0] w3_prod [CH];
    logic                       w3_neg  [CH];

    always_comb begin
        logic signed [ACCW:0] x;
        logic [ACCW:0]        mag;
        logic [PW-1:0]        offk;
        for (int k = 0; k < CH; k++) begin
            offk       = (k == 1 || k == 2) ? w_off : '0;
            x          = 17'($signed(r3_acc[k*ACCW +: ACCW])) - $signed({9'd0, offk});
            w3_neg[k]  = x[ACCW];
            mag        = w3_neg[k] ? 17'(-x) : 17'(x);
            w3_prod[k] = tpa_pkg::PROD_W'(mag) * tpa_pkg::PROD_W'(w_recip[w_n]);
        end
    end

    logic                       r4_last;
    logic [tpa_pkg::PROD_W-1:0] r4_prod [CH];
    logic                       r4_neg  [CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_addr <= r3_addr;
            r4_hidx <= r3_hidx;
            r4_hist <= r3_hist;
            r4_acc  <= r3_acc;
            r4_last <= r3_last;
            r4_prod <= w3_prod;
            r4_neg  <= w3_neg;
        end
    end

    // ---------------- stage 4: quotient, output register ----------------
    logic [PWW-1:0] w4_data;

    always_comb begin
        logic [PW-1:0] q8;
        logic [PW-1:0] offk;
        for (int k = 0; k < CH; k++) begin
            offk = (k == 1 || k == 2) ? w_off : '0;
            q8   = r4_prod[k][tpa_pkg::RECIP_SHIFT +: PW];
            if (w_mode == tpa_pkg::MODE_AVERAGE) begin
                w4_data[k*PW +: PW] = (r4_neg[k] ? (8'd0 - q8) : q8) + offk;
            end else begin
                w4_data[k*PW +: PW] = r4_acc[k*ACCW +: PW];
            end
        end
        if (!w_four) begin
            w4_data[3*PW +: PW] = '0;
        end
    end

    logic [PWW-1:0] r5_data;
    logic           r5_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_addr <= r4_addr;
            r5_hidx <= r4_hidx;
            r5_hist <= r4_hist;
            r5_acc  <= r4_acc;
            r5_data <= w4_data;
            r5_last <= r4_last;
        end
    end

    assign m_axis_tvalid = r5_valid;
    assign m_axis_tdata  = r5_data;
    assign m_axis_tlast  = r5_last;

    // ---------------- checks ----------------
    `TPA_ASSERT_IMPLIES(a_fill_bound, 1'b1, 32'(r_filled) <= MAX_WINDOW, "fill count above window")
    `TPA_ASSERT_NEXT(a_ring_wrap, acc_in && s_axis_tlast, NW'(r_ring) < w_n, "ring slot not wrapped")
    `TPA_ASSERT_NEXT(a_enter_pipe, acc_in, r1_valid, "accepted request lost at stage one")

endmodule
